FILE: hw/rtl/afl_pkg.sv
package afl_pkg;

  localparam int unsigned MinLoop    = 128;
  localparam int unsigned GuardSlots = 8;
  localparam logic [23:0] PhaseHalf  = 24'h800000;
  localparam logic [23:0] PhaseMask  = 24'hFFFFFF;
  localparam logic [15:0] CoeffReset = 16'd170;
  localparam logic [63:0] PiQ30      = 64'd3373259426;
  localparam int unsigned RecipSteps = 18;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_OFF,
    ST_IDX,
    ST_RD0,
    ST_RD1,
    ST_INT,
    ST_WIN,
    ST_ACC,
    ST_FADE,
    ST_FADE2,
    ST_MIX,
    ST_OUT
  } afl_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } recip_status_t;

  typedef logic [15:0] sin_tab_t [257];

  // Q15 sin(pi*k/256) from a fixed Q30 Taylor series, mirrored about k = 128
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    for (int k = 0; k <= 128; k++) begin
      x    = (PiQ30 * 64'(k)) >> 8;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = 0;
      end
      e = ($unsigned(sum) + 64'd16384) >> 15;
      t[k]       = e[15:0];
      t[256 - k] = e[15:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

FILE: hw/rtl/afl_ram.sv
module afl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/afl_recip.sv
// floor(2^24 / len), one quotient bit per cycle
module afl_recip
  import afl_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   len_i,
  output recip_status_t status_o,
  output logic [17:0]   quot_o
);

  logic [15:0] rem_q, rem_d;
  logic [17:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] shifted;

  assign shifted = {rem_q, 1'b0};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // the top seven dividend bits leave 64, below any legal length
      rem_d  = 16'd64;
      quot_d = '0;
      cnt_d  = 5'(RecipSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, len_i}) begin
        rem_d  = 16'(shifted - {1'b0, len_i});
        quot_d = {quot_q[16:0], 1'b1};
      end else begin
        rem_d  = shifted[15:0];
        quot_d = {quot_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

FILE: hw/rtl/audio_freeze_looper.sv
// A request runs the bit-serial reciprocal (ST_DIV), then two read heads, each through
// ST_OFF, ST_IDX, ST_RD0, ST_RD1, ST_INT, ST_WIN and ST_ACC, as the sample store has a
// single read port, then ST_FADE, ST_FADE2, ST_MIX and ST_OUT. One request at a time:
// the next is taken only in ST_IDLE. Reset clears control state; the sample store is
// never cleared, unwritten slots read as zero through the write pointer and a wrap flag.
module audio_freeze_looper
  import afl_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,      // crossfade_coeff
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // in_sample [15:0], loop_length [31:16]
  input  logic        s_axis_tuser_i,  // freeze_gate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // out_sample
);

  localparam int unsigned AW     = $clog2(BUFFER_DEPTH);
  localparam int unsigned LenMax = BUFFER_DEPTH - GuardSlots;

  afl_state_e state_q, state_d;

  logic [15:0]        coeff_q;
  logic [AW-1:0]      wp_q, fp_q;
  logic               wrapped_q, frozen_q;
  logic [23:0]        phase_q, fade_q;
  logic signed [15:0] dry_q;
  logic [15:0]        len_q;
  logic               head_q;

  logic [39:0]        off_q;
  logic [15:0]        ta_q;
  logic signed [33:0] wprod_q;
  logic [AW-1:0]      i0_q, i1_q;
  logic [15:0]        fr_q;
  logic               rv_q;
  logic signed [15:0] a_q;
  logic signed [33:0] iprod_q;
  logic signed [33:0] ws_q;
  logic signed [34:0] acc_q;
  logic signed [41:0] fprod_q;
  logic signed [43:0] mprod_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  logic               in_acc, out_load;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;
  logic               div_start;
  recip_status_t      div_st;
  logic [17:0]        div_q;

  logic [15:0]        in_len, len_sat;
  logic               gate;
  logic [23:0]        phase_h;
  logic [AW+1:0]      idx_sum;
  logic [AW-1:0]      i0_c;
  logic [15:0]        tb;
  logic signed [15:0] rd_val;
  logic signed [16:0] w_c, s_c;
  logic signed [17:0] frozen_c;
  logic signed [19:0] y_c;
  logic [23:0]        fade_new;
  logic [23:0]        target;

  assign cfg_ready_o = 1'b1;
  assign gate        = s_axis_tuser_i;
  assign in_len      = s_axis_tdata_i[31:16];

  always_comb begin
    len_sat = in_len;
    if (32'(in_len) < MinLoop) begin
      len_sat = 16'(MinLoop);
    end else if (32'(in_len) > LenMax) begin
      len_sat = 16'(LenMax);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_DIV;
      ST_DIV:   if (div_st.done) state_d = ST_OFF;
      ST_OFF:   state_d = ST_IDX;
      ST_IDX:   state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_INT;
      ST_INT:   state_d = ST_WIN;
      ST_WIN:   state_d = ST_ACC;
      ST_ACC:   state_d = head_q ? ST_FADE : ST_OFF;
      ST_FADE:  state_d = ST_FADE2;
      ST_FADE2: state_d = ST_MIX;
      ST_MIX:   state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = i0_q;
    out_load        = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_RD0:  ram_re = 1'b1;
      ST_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = i1_q;
      end
      ST_OUT:  out_load = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign ram_we    = in_acc && !gate;
  assign div_start = in_acc;

  afl_ram #(
    .WIDTH (16),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata_i[15:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  afl_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .len_i    (len_q),
    .status_o (div_st),
    .quot_o   (div_q)
  );

  assign phase_h = head_q ? phase_q + PhaseHalf : phase_q;
  assign tb      = SinTab[9'(phase_h[23:16]) + 9'd1];

  assign idx_sum = (AW+2)'(fp_q) + (AW+2)'(BUFFER_DEPTH) - (AW+2)'(len_q)
                 + (AW+2)'(off_q[39:24]);
  assign i0_c    = (idx_sum >= (AW+2)'(BUFFER_DEPTH)) ?
                   AW'(idx_sum - (AW+2)'(BUFFER_DEPTH)) : AW'(idx_sum);

  assign rd_val  = rv_q ? $signed(ram_rdata) : 16'sd0;
  assign w_c     = $signed({1'b0, ta_q}) + $signed(wprod_q[32:16]);
  assign s_c     = 17'(a_q) + $signed(iprod_q[32:16]);
  assign frozen_c = $signed(acc_q[32:15]);
  assign target  = frozen_q ? PhaseMask : 24'd0;
  assign fade_new = 24'($signed({1'b0, fade_q}) + $signed(fprod_q[40:16]));
  assign y_c     = 20'(dry_q) + 20'($signed(mprod_q[42:24]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      coeff_q     <= CoeffReset;
      wp_q        <= '0;
      fp_q        <= '0;
      wrapped_q   <= 1'b0;
      frozen_q    <= 1'b0;
      phase_q     <= '0;
      fade_q      <= '0;
      head_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        coeff_q <= cfg_data_i;
      end
      if (in_acc) begin
        frozen_q <= gate;
        if (gate && !frozen_q) begin
          fp_q    <= wp_q;
          phase_q <= '0;
        end
        if (!gate) begin
          if (wp_q == AW'(BUFFER_DEPTH - 1)) begin
            wp_q      <= '0;
            wrapped_q <= 1'b1;
          end else begin
            wp_q <= wp_q + AW'(1);
          end
        end
      end
      if (state_q == ST_DIV && div_st.done) begin
        phase_q <= phase_q + 24'(div_q);
        head_q  <= 1'b0;
      end
      if (state_q == ST_ACC) begin
        head_q <= 1'b1;
      end
      if (state_q == ST_FADE2) begin
        fade_q <= fade_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q <= $signed(s_axis_tdata_i[15:0]);
      len_q <= len_sat;
    end
    if (state_q == ST_DIV) begin
      acc_q <= '0;
    end
    case (state_q)
      ST_OFF: begin
        off_q   <= 40'(phase_h) * 40'(len_q);
        ta_q    <= SinTab[9'(phase_h[23:16])];
        wprod_q <= 34'($signed({1'b0, tb}) - $signed({1'b0, SinTab[9'(phase_h[23:16])]}))
                   * $signed({18'd0, phase_h[15:0]});
      end
      ST_IDX: begin
        i0_q <= i0_c;
        i1_q <= (i0_c == AW'(BUFFER_DEPTH - 1)) ? '0 : i0_c + AW'(1);
        fr_q <= off_q[23:8];
      end
      ST_RD0:  rv_q <= wrapped_q || (i0_q < wp_q);
      ST_RD1: begin
        a_q  <= rd_val;
        rv_q <= wrapped_q || (i1_q < wp_q);
      end
      ST_INT:  iprod_q <= 34'(17'(rd_val) - 17'(a_q)) * $signed({18'd0, fr_q});
      ST_WIN:  ws_q <= 34'(w_c) * 34'(s_c);
      ST_ACC:  acc_q <= acc_q + 35'(ws_q);
      ST_FADE: fprod_q <= $signed({17'd0, coeff_q[15:0], 9'd0} >> 9)
                          * 42'($signed({1'b0, target}) - $signed({1'b0, fade_q}));
      ST_MIX:  mprod_q <= $signed({20'd0, fade_q})
                          * 44'(19'(frozen_c) - 19'(dry_q));
      default: ;
    endcase
    if (out_load) begin
      if (y_c > 20'sd32767) begin
        out_data_q <= 16'h7FFF;
      end else if (y_c < -20'sd32768) begin
        out_data_q <= 16'h8000;
      end else begin
        out_data_q <= y_c[15:0];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_ram_write_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_IDLE)
    else $error("store written outside acceptance");

  a_recip_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV)
    else $error("reciprocal finished outside wait state");

  a_freeze_point_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(fp_q))
    else $error("freeze point moved without a request");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("pending result overwritten");

  a_busy_blocks_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !s_axis_tready_o)
    else $error("request taken while reciprocal busy");

endmodule
